// ===== hdl/mpfld_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpfld_pkg
// Shared types and constants of the pulse-frame locomotive decoder.
// ----------------------------------------------------------------------------
package mpfld_pkg;

    localparam int FRAME_BITS = 18;
    localparam int ADDR_BITS  = 8;
    localparam int FUNC_BITS  = 2;
    localparam int IDX_W      = 5;

    localparam logic [IDX_W-1:0] LAST_BIT  = IDX_W'(FRAME_BITS - 1);
    localparam logic [IDX_W-1:0] ADDR_END  = IDX_W'(ADDR_BITS);
    localparam logic [IDX_W-1:0] FUNC_END  = IDX_W'(ADDR_BITS + FUNC_BITS);
    localparam logic [IDX_W-1:0] FRAME_END = IDX_W'(FRAME_BITS);
    localparam logic [IDX_W-1:0] IDX_SAT   = '1;

    // event codes
    localparam logic [1:0] KIND_FALL = 2'd0;
    localparam logic [1:0] KIND_RISE = 2'd1;
    localparam logic [1:0] KIND_OVF  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_OWN_ADDR   = 3'd0;
    localparam logic [2:0] REG_LIGHT_ALW  = 3'd1;
    localparam logic [2:0] REG_ONE_MIN    = 3'd2;
    localparam logic [2:0] REG_ONE_MAX    = 3'd3;
    localparam logic [2:0] REG_PERIOD_MIN = 3'd4;
    localparam logic [2:0] REG_PERIOD_MAX = 3'd5;

    localparam logic [7:0] RST_ONE_MIN    = 8'd180;
    localparam logic [7:0] RST_ONE_MAX    = 8'd200;
    localparam logic [7:0] RST_PERIOD_MIN = 8'd200;
    localparam logic [7:0] RST_PERIOD_MAX = 8'd230;

    // mirror nibble codes
    localparam logic [3:0] MIR_REV_FN = 4'b0101;
    localparam logic [3:0] MIR_FWD_FN = 4'b1010;
    localparam logic [3:0] MIR_REV    = 4'b1101;
    localparam logic [3:0] MIR_FWD    = 4'b0010;
    localparam logic [3:0] MIR_F1_OFF = 4'b0011;
    localparam logic [3:0] MIR_F1_ON  = 4'b1011;
    localparam logic [3:0] MIR_F2_OFF = 4'b0100;
    localparam logic [3:0] MIR_F2_ON  = 4'b1100;
    localparam logic [3:0] MIR_F3_OFF = 4'b0110;
    localparam logic [3:0] MIR_F3_ON  = 4'b1110;
    localparam logic [3:0] MIR_F4_OFF = 4'b0111;
    localparam logic [3:0] MIR_F4_ON  = 4'b1111;

    localparam logic [3:0] STEP_TOGGLE = 4'd1;
    localparam logic [3:0] STEP_DIR_LIMIT = 4'd6;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ticks;
    } t_evt_item;

    typedef struct packed {
        logic [7:0] drive_a;
        logic [7:0] drive_b;
        logic       light_a;
        logic       light_b;
        logic       direction;
        logic       save_direction;
        logic [3:0] function_states;
        logic       command_taken;
    } t_res_item;

    typedef struct packed {
        logic [2:0] reg_index;
        logic [7:0] data;
    } t_cfg_item;

    typedef struct packed {
        logic [7:0] own_address;
        logic       light_always;
        logic [7:0] one_min;
        logic [7:0] one_max;
        logic [7:0] period_min;
        logic [7:0] period_max;
    } t_cfg;

    typedef struct packed {
        logic       match;
        logic [7:0] addr;
        logic [7:0] func;
        logic [7:0] speed;
    } t_frame;

    typedef struct packed {
        logic       dir;
        logic [3:0] aux;
        logic       light_on;
        logic [3:0] step;
    } t_loco;

endpackage
`default_nettype wire

// ===== hdl/mpfld_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpfld_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface mpfld_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/mpfld_frame_rx.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpfld_frame_rx
// Bit timing, frame assembly and repeat detection.
// ----------------------------------------------------------------------------
module mpfld_frame_rx
    import mpfld_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [1:0] i_kind,
    input  wire logic [7:0] i_ticks,
    input  wire t_cfg       i_cfg,
    output t_frame          o_frame
);

    logic [IDX_W-1:0] r_bit, n_bit, bi;
    logic [7:0]       r_high, n_high;
    logic             r_run, n_run;
    logic [7:0]       r_addr, n_addr, r_func, n_func, r_speed, n_speed;
    logic [7:0]       r_paddr, n_paddr, r_pfunc, n_pfunc, r_pspeed, n_pspeed;
    logic [7:0]       a_base, f_base, s_base, spd_last;
    logic             one_rise, one_fall, period_ok, same;

    assign one_rise  = (r_high > i_cfg.one_min) && (r_high < i_cfg.one_max);
    assign one_fall  = (i_ticks > i_cfg.one_min) && (i_ticks < i_cfg.one_max);
    assign period_ok = (i_ticks > i_cfg.period_min) && (i_ticks < i_cfg.period_max);
    assign spd_last  = {one_fall, r_speed[7:1]};
    assign same      = (r_paddr == r_addr) && (r_pfunc == r_func) && (r_pspeed == spd_last);
    assign bi        = r_run ? r_bit : '0;
    assign a_base    = (bi == '0) ? 8'd0 : r_addr;
    assign f_base    = (bi == '0) ? 8'd0 : r_func;
    assign s_base    = (bi == '0) ? 8'd0 : r_speed;

    always_comb begin
        n_bit    = r_bit;
        n_high   = r_high;
        n_run    = r_run;
        n_addr   = r_addr;
        n_func   = r_func;
        n_speed  = r_speed;
        n_paddr  = r_paddr;
        n_pfunc  = r_pfunc;
        n_pspeed = r_pspeed;
        o_frame.match = 1'b0;
        o_frame.addr  = r_addr;
        o_frame.func  = r_func;
        o_frame.speed = spd_last;
        case (i_kind)
            KIND_FALL: begin
                n_high = i_ticks;
                if (r_bit == LAST_BIT) begin
                    n_bit = '0;
                    if (same) begin
                        o_frame.match = 1'b1;
                        n_addr   = '0;
                        n_func   = '0;
                        n_speed  = '0;
                        n_paddr  = '0;
                        n_pfunc  = '0;
                        n_pspeed = '0;
                    end else begin
                        n_speed  = spd_last;
                        n_paddr  = r_addr;
                        n_pfunc  = r_func;
                        n_pspeed = spd_last;
                    end
                end
            end
            KIND_RISE: begin
                n_run = 1'b1;
                if (period_ok) begin
                    n_addr  = a_base;
                    n_func  = f_base;
                    n_speed = s_base;
                    if (bi < ADDR_END) begin
                        n_addr = {one_rise, a_base[7:1]};
                    end else if (bi < FUNC_END) begin
                        n_func = {one_rise, f_base[7:1]};
                    end else if (bi < FRAME_END) begin
                        n_speed = {one_rise, s_base[7:1]};
                    end
                    n_bit = (bi == IDX_SAT) ? IDX_SAT : bi + 1'b1;
                end else begin
                    n_bit = '0;
                end
            end
            KIND_OVF: begin
                n_run = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit    <= '0;
            r_high   <= '0;
            r_run    <= 1'b0;
            r_addr   <= '0;
            r_func   <= '0;
            r_speed  <= '0;
            r_paddr  <= '0;
            r_pfunc  <= '0;
            r_pspeed <= '0;
        end else if (i_step) begin
            r_bit    <= n_bit;
            r_high   <= n_high;
            r_run    <= n_run;
            r_addr   <= n_addr;
            r_func   <= n_func;
            r_speed  <= n_speed;
            r_paddr  <= n_paddr;
            r_pfunc  <= n_pfunc;
            r_pspeed <= n_pspeed;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/mpfld_cmd_apply.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpfld_cmd_apply
// Applies a confirmed command: direction, functions, light and speed step.
// ----------------------------------------------------------------------------
module mpfld_cmd_apply
    import mpfld_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_apply,
    input  wire logic [7:0] i_func,
    input  wire logic [7:0] i_speed,
    output t_loco           o_state,
    output logic            o_save
);

    t_loco      r_loco, n_loco;
    logic       r_block, n_block;
    logic [3:0] mir, st;
    logic       fn_we, fn_val, dir_r;
    logic [1:0] fn_idx;

    assign mir = {i_speed[7], i_speed[5], i_speed[3], i_speed[1]};
    assign st  = {i_speed[6], i_speed[4], i_speed[2], i_speed[0]};

    always_comb begin
        fn_we  = 1'b0;
        fn_idx = 2'd0;
        fn_val = 1'b0;
        dir_r  = r_loco.dir;
        if (st != mir) begin
            case (mir)
                MIR_REV_FN: begin
                    if (st > STEP_DIR_LIMIT) begin
                        dir_r = 1'b0;
                    end else begin
                        fn_val = 1'b0;
                        case (st)
                            4'd2:    begin fn_we = 1'b1; fn_idx = 2'd0; end
                            4'd3:    begin fn_we = 1'b1; fn_idx = 2'd1; end
                            4'd5:    begin fn_we = 1'b1; fn_idx = 2'd2; end
                            4'd6:    begin fn_we = 1'b1; fn_idx = 2'd3; end
                            default: begin end
                        endcase
                    end
                end
                MIR_FWD_FN: begin
                    if (st <= STEP_DIR_LIMIT) begin
                        dir_r = 1'b1;
                    end else begin
                        fn_val = 1'b1;
                        case (st)
                            4'd10:   begin fn_we = 1'b1; fn_idx = 2'd0; end
                            4'd11:   begin fn_we = 1'b1; fn_idx = 2'd1; end
                            4'd13:   begin fn_we = 1'b1; fn_idx = 2'd2; end
                            4'd14:   begin fn_we = 1'b1; fn_idx = 2'd3; end
                            default: begin end
                        endcase
                    end
                end
                MIR_REV: begin
                    if (st <= STEP_DIR_LIMIT) begin
                        dir_r = 1'b0;
                    end
                end
                MIR_FWD: begin
                    if (st > STEP_DIR_LIMIT) begin
                        dir_r = 1'b1;
                    end
                end
                MIR_F1_OFF: begin fn_we = 1'b1; fn_idx = 2'd0; fn_val = 1'b0; end
                MIR_F1_ON:  begin fn_we = 1'b1; fn_idx = 2'd0; fn_val = 1'b1; end
                MIR_F2_OFF: begin fn_we = 1'b1; fn_idx = 2'd1; fn_val = 1'b0; end
                MIR_F2_ON:  begin fn_we = 1'b1; fn_idx = 2'd1; fn_val = 1'b1; end
                MIR_F3_OFF: begin fn_we = 1'b1; fn_idx = 2'd2; fn_val = 1'b0; end
                MIR_F3_ON:  begin fn_we = 1'b1; fn_idx = 2'd2; fn_val = 1'b1; end
                MIR_F4_OFF: begin fn_we = 1'b1; fn_idx = 2'd3; fn_val = 1'b0; end
                MIR_F4_ON:  begin fn_we = 1'b1; fn_idx = 2'd3; fn_val = 1'b1; end
                default:    begin end
            endcase
        end
    end

    always_comb begin
        n_loco  = r_loco;
        n_block = r_block;
        o_save  = 1'b0;
        if (i_apply) begin
            n_loco.dir = dir_r;
            if (fn_we) begin
                n_loco.aux[fn_idx] = fn_val;
            end
            n_loco.light_on = (i_func != 8'd0);
            if (st == STEP_TOGGLE) begin
                if (!r_block) begin
                    n_loco.dir = ~dir_r;
                    o_save     = 1'b1;
                end
                n_loco.step = 4'd0;
                n_block     = 1'b1;
            end else begin
                n_loco.step = st;
                n_block     = 1'b0;
            end
        end
    end

    assign o_state = n_loco;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loco  <= '0;
            r_block <= 1'b0;
        end else begin
            r_loco  <= n_loco;
            r_block <= n_block;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/mm_pulse_frame_loco_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mm_pulse_frame_loco_decoder
// Locomotive decoder for pulse-width frames built from timed edge events.
// ----------------------------------------------------------------------------
// path: an event transfer reaches the result transfer through the input register and the result register
// throughput: one event per cycle while the sink is ready, set by the single pass from input to result register
// the result register holds while the sink stalls; one more event waits in the input register
// reset: synchronous active low; clears frame state and loco state, loads configuration defaults
// configuration writes are registered when valid, the port is always ready
module mm_pulse_frame_loco_decoder
    import mpfld_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    mpfld_stream_if.sink   i_evt,
    mpfld_stream_if.source o_res,
    mpfld_stream_if.sink   i_cfg
);

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_evt_item r_in;
    logic      r_out_valid;
    t_res_item r_out, n_out;
    logic      advance, apply;
    t_frame    frame;
    t_loco     loco;
    logic      save;
    logic      lit;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_address  <= '0;
            r_cfg.light_always <= 1'b0;
            r_cfg.one_min      <= RST_ONE_MIN;
            r_cfg.one_max      <= RST_ONE_MAX;
            r_cfg.period_min   <= RST_PERIOD_MIN;
            r_cfg.period_max   <= RST_PERIOD_MAX;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.payload.reg_index)
                REG_OWN_ADDR:   r_cfg.own_address  <= i_cfg.payload.data;
                REG_LIGHT_ALW:  r_cfg.light_always <= i_cfg.payload.data[0];
                REG_ONE_MIN:    r_cfg.one_min      <= i_cfg.payload.data;
                REG_ONE_MAX:    r_cfg.one_max      <= i_cfg.payload.data;
                REG_PERIOD_MIN: r_cfg.period_min   <= i_cfg.payload.data;
                REG_PERIOD_MAX: r_cfg.period_max   <= i_cfg.payload.data;
                default: begin end
            endcase
        end
    end

    // pipeline control
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_evt.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_in_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_in <= i_evt.payload;
        end
    end

    mpfld_frame_rx u_frame_rx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_kind  (r_in.kind),
        .i_ticks (r_in.ticks),
        .i_cfg   (r_cfg),
        .o_frame (frame)
    );

    assign apply = advance && frame.match && (frame.addr == r_cfg.own_address);

    mpfld_cmd_apply u_cmd_apply (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_apply (apply),
        .i_func  (frame.func),
        .i_speed (frame.speed),
        .o_state (loco),
        .o_save  (save)
    );

    assign lit = loco.light_on | r_cfg.light_always;

    always_comb begin
        n_out.drive_a         = loco.dir ? 8'd0 : {loco.step, 4'd0};
        n_out.drive_b         = loco.dir ? {loco.step, 4'd0} : 8'd0;
        n_out.light_a         = lit & loco.dir;
        n_out.light_b         = lit & ~loco.dir;
        n_out.direction       = loco.dir;
        n_out.save_direction  = save;
        n_out.function_states = loco.aux;
        n_out.command_taken   = apply;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

`ifndef SYNTHESIS
    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result register not loaded after advance");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_evt.ready)
        else $error("input stalled with empty result register");

    a_save_needs_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        save |-> apply)
        else $error("direction save strobe without an applied command");

    a_one_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.drive_a == 8'd0 || r_out.drive_b == 8'd0))
        else $error("both motor sides driven");

    a_save_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        save |-> (loco.step == 4'd0))
        else $error("save strobe with a non-zero speed step");
`endif

endmodule
`default_nettype wire
